@@ rtl/core/spq_pkg.sv @@
// Package for the sorted priority stack: default sizes, operation and error codes,
// and the control struct sent to the cells. No dependencies.
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int ELEM_BITS_DEF = 32;
	localparam int PRIO_BITS_DEF = 8;

	// operation codes carried in the kind field
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} spq_err_t;

	// move applied to every cell together
	typedef struct packed {
		logic push;
		logic pop;
	} spq_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/spq_req_if.sv @@
// Request channel of the sorted priority stack: valid/ready plus one operation item.
// Depends on spq_pkg.
`default_nettype none

interface spq_req_if #(
	parameter int ELEM_BITS = spq_pkg::ELEM_BITS_DEF,
	parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [ELEM_BITS-1:0] elem;
	logic [PRIO_BITS-1:0] prio;

	modport source (output valid, kind, elem, prio, input ready);
	modport sink   (input valid, kind, elem, prio, output ready);
endinterface

`default_nettype wire

@@ rtl/core/spq_rsp_if.sv @@
// Result channel of the sorted priority stack: valid/ready plus the head and status.
// Depends on spq_pkg.
`default_nettype none

interface spq_rsp_if #(
	parameter int ELEM_BITS = spq_pkg::ELEM_BITS_DEF,
	parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
	parameter int CNT_BITS  = $clog2(spq_pkg::DEPTH_DEF + 1)
);
	logic                 valid;
	logic                 ready;
	logic [ELEM_BITS-1:0] top_elem;
	logic [PRIO_BITS-1:0] top_prio;
	logic                 empty_flag;
	logic [CNT_BITS-1:0]  count;
	logic [1:0]           error;

	modport source (output valid, top_elem, top_prio, empty_flag, count, error, input ready);
	modport sink   (input valid, top_elem, top_prio, empty_flag, count, error, output ready);
endinterface

`default_nettype wire

@@ rtl/core/spq_cell.sv @@
// One slot of the sorted chain: holds an element and priority, compares against the
// pushed priority, and shifts with its neighbors. Depends on spq_pkg.
`default_nettype none

module spq_cell #(
	parameter int ELEM_BITS = spq_pkg::ELEM_BITS_DEF,
	parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire spq_pkg::spq_ctl_t    ctl,
	input  wire logic                 occupied,
	input  wire logic [ELEM_BITS-1:0] new_elem,
	input  wire logic [PRIO_BITS-1:0] new_prio,
	input  wire logic                 left_greater,
	input  wire logic [ELEM_BITS-1:0] left_elem,
	input  wire logic [PRIO_BITS-1:0] left_prio,
	input  wire logic [ELEM_BITS-1:0] right_elem,
	input  wire logic [PRIO_BITS-1:0] right_prio,
	output logic                      greater,
	output logic [ELEM_BITS-1:0]      elem,
	output logic [PRIO_BITS-1:0]      prio
);
	import spq_pkg::*;

	logic [ELEM_BITS-1:0] elem_q, elem_d;
	logic [PRIO_BITS-1:0] prio_q, prio_d;
	logic                 take_new;

	// stored entries ahead of the insert point hold a strictly larger priority
	assign greater  = occupied && (prio_q > new_prio);
	assign take_new = !greater && left_greater;

	always_comb begin
		elem_d = elem_q;
		prio_d = prio_q;
		if (ctl.push) begin
			if (take_new) begin
				elem_d = new_elem;
				prio_d = new_prio;
			end else if (!greater) begin
				elem_d = left_elem;
				prio_d = left_prio;
			end
		end else if (ctl.pop) begin
			elem_d = right_elem;
			prio_d = right_prio;
		end
	end

	always_ff @(posedge clk) begin
		elem_q <= elem_d;
		prio_q <= prio_d;
	end

	assign elem = elem_q;
	assign prio = prio_q;

endmodule

`default_nettype wire

@@ rtl/core/sorted_priority_stack_top.sv @@
// Top level of the sorted priority stack: count register, result register and the
// chain of spq_cell slots. Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_cell.
`default_nettype none

// Bounded priority stack of DEPTH entries, kept sorted highest priority first in a
// row of cells. A push goes ahead of the first entry whose priority is less than or
// equal to its own, so equal priorities come out last-in first-out; a pop drops the
// head. Every accepted item yields exactly one result item with the head element and
// priority (both zero when empty), an empty flag, the entry count and an error code
// (pop on empty or push on full is ignored and flagged). Throughput is one item per
// cycle: every cell compares and shifts in the same cycle the item is accepted, and
// the result comes out on the next cycle. A new item is taken whenever the result
// slot is free or its result is being taken in that cycle, so a stalled result
// channel stalls the request channel. No clearing pass after reset: only the count,
// the result valid flag and the error code are reset.
module sorted_priority_stack_top #(
	parameter int DEPTH     = spq_pkg::DEPTH_DEF,
	parameter int ELEM_BITS = spq_pkg::ELEM_BITS_DEF,
	parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);
	localparam logic [CNT_BITS-1:0] ONE_CNT  = CNT_BITS'(1);

	logic [CNT_BITS-1:0] count_q;
	logic                rsp_valid_q;
	spq_err_t            err_q, err_d;
	logic                accept;
	logic                full, empty;
	spq_ctl_t            ctl;

	// chain taps
	logic [ELEM_BITS-1:0] cell_elem [DEPTH];
	logic [PRIO_BITS-1:0] cell_prio [DEPTH];
	logic                 cell_greater [DEPTH];

	assign full   = (count_q == FULL_CNT);
	assign empty  = (count_q == '0);
	// head and count are read straight off the state; the state only moves when the
	// held result is being drained, so it always matches the result being shown
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign ctl.push = accept && (req.kind == KIND_PUSH) && !full;
	assign ctl.pop  = accept && (req.kind == KIND_POP) && !empty;

	always_comb begin
		err_d = ERR_NONE;
		if (req.kind == KIND_PUSH && full)
			err_d = ERR_FULL;
		else if (req.kind == KIND_POP && empty)
			err_d = ERR_EMPTY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			err_q       <= ERR_NONE;
		end else begin
			if (ctl.push)
				count_q <= count_q + ONE_CNT;
			else if (ctl.pop)
				count_q <= count_q - ONE_CNT;
			if (accept) begin
				rsp_valid_q <= 1'b1;
				err_q       <= err_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// cell 0 sees a "greater" neighbor so it takes the new item when nothing is ahead;
	// the last cell's right neighbor is never used on a valid slot
	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                 lg;
			logic [ELEM_BITS-1:0] le, re;
			logic [PRIO_BITS-1:0] lp, rp;
			if (i == 0) begin : g_first
				assign lg = 1'b1;
				assign le = req.elem;
				assign lp = req.prio;
			end else begin : g_mid
				assign lg = cell_greater[i-1];
				assign le = cell_elem[i-1];
				assign lp = cell_prio[i-1];
			end
			if (i == DEPTH - 1) begin : g_last
				assign re = cell_elem[i];
				assign rp = cell_prio[i];
			end else begin : g_inner
				assign re = cell_elem[i+1];
				assign rp = cell_prio[i+1];
			end

			spq_cell #(
				.ELEM_BITS(ELEM_BITS),
				.PRIO_BITS(PRIO_BITS)
			) u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occupied    (CNT_BITS'(i) < count_q),
				.new_elem    (req.elem),
				.new_prio    (req.prio),
				.left_greater(lg),
				.left_elem   (le),
				.left_prio   (lp),
				.right_elem  (re),
				.right_prio  (rp),
				.greater     (cell_greater[i]),
				.elem        (cell_elem[i]),
				.prio        (cell_prio[i])
			);
		end
	endgenerate

	assign rsp.valid      = rsp_valid_q;
	assign rsp.top_elem   = empty ? '0 : cell_elem[0];
	assign rsp.top_prio   = empty ? '0 : cell_prio[0];
	assign rsp.empty_flag = empty;
	assign rsp.count      = count_q;
	assign rsp.error      = err_q;

	// count stays within the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	// an accepted push with room grows the count by one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == KIND_PUSH && !full) |=> (count_q == $past(count_q) + ONE_CNT))
		else $error("push did not grow count");

	// a full-push error is only reported with the store full
	a_full_err: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && err_q == ERR_FULL) |-> full)
		else $error("full error with room left");

	// head never ranks below the second entry
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > ONE_CNT) |-> (cell_prio[0] >= cell_prio[1]))
		else $error("head out of order");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_priority_stack_top: a directed table, then random push/pop traffic.
// Results are checked against a sorted-stack model in this file or a row's given answer.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the RTL of the block.

module tb_top;
	import spq_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int N_RANDOM       = 1350;
	localparam int HOLD_CYCLES    = 300;   // long result stall, backs up the request channel
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
	localparam int MAX_REPORTS    = 10;

	// head of the stack and status, as reported after each item
	typedef struct packed {
		logic [31:0] elem;
		logic [7:0]  prio;
		logic        empty;
		logic [4:0]  cnt;
		spq_err_t    err;
	} head_t;

	// per-item note from the sender: a typed-in expectation overrides the model
	typedef struct packed {
		logic  given;
		head_t res;
	} tag_t;

	// one row of the directed table; push rows with reps > 1 bump elem per repeat
	typedef struct packed {
		logic        kind;
		logic [31:0] elem;
		logic [7:0]  prio;
		logic [4:0]  reps;
		logic        given;
		head_t       res;
	} row_t;

	localparam head_t NO_RES = '{32'h0, 8'h00, 1'b0, 5'd0, ERR_NONE};

	localparam int N_ROWS = 14;
	localparam row_t PLAN [N_ROWS] = '{
		// pop on an empty store is ignored and flagged
		'{KIND_POP,  32'h0000_0000, 8'h00, 5'd1,  1'b1, '{32'h0, 8'h00, 1'b1, 5'd0, ERR_EMPTY}},
		// lowest priority, zero element
		'{KIND_PUSH, 32'h0000_0000, 8'h00, 5'd1,  1'b1, '{32'h0, 8'h00, 1'b0, 5'd1, ERR_NONE}},
		// highest priority, all-ones element goes to the head
		'{KIND_PUSH, 32'hFFFF_FFFF, 8'hFF, 5'd1,  1'b1,
			'{32'hFFFF_FFFF, 8'hFF, 1'b0, 5'd2, ERR_NONE}},
		// equal priority: newcomer goes ahead of the stored one
		'{KIND_PUSH, 32'h1234_5678, 8'hFF, 5'd1,  1'b1,
			'{32'h1234_5678, 8'hFF, 1'b0, 5'd3, ERR_NONE}},
		'{KIND_PUSH, 32'hA5A5_A5A5, 8'h80, 5'd1,  1'b0, NO_RES},
		// tie at the tail
		'{KIND_PUSH, 32'h5A5A_5A5A, 8'h00, 5'd1,  1'b0, NO_RES},
		'{KIND_POP,  32'h0000_0000, 8'h00, 5'd1,  1'b1,
			'{32'hFFFF_FFFF, 8'hFF, 1'b0, 5'd4, ERR_NONE}},
		// fill up to DEPTH
		'{KIND_PUSH, 32'h0000_0100, 8'h40, 5'd12, 1'b0, NO_RES},
		// push on a full store is ignored, head unchanged
		'{KIND_PUSH, 32'hC3C3_C3C3, 8'hFF, 5'd1,  1'b1,
			'{32'hFFFF_FFFF, 8'hFF, 1'b0, 5'd16, ERR_FULL}},
		// drain; pop payload is don't-care so drive it busy
		'{KIND_POP,  32'hFFFF_FFFF, 8'hFF, 5'd15, 1'b0, NO_RES},
		'{KIND_POP,  32'h0000_0000, 8'h00, 5'd1,  1'b1, '{32'h0, 8'h00, 1'b1, 5'd0, ERR_NONE}},
		'{KIND_POP,  32'h0000_0000, 8'h00, 5'd1,  1'b1, '{32'h0, 8'h00, 1'b1, 5'd0, ERR_EMPTY}},
		'{KIND_PUSH, 32'hDEAD_BEEF, 8'h7F, 5'd1,  1'b1,
			'{32'hDEAD_BEEF, 8'h7F, 1'b0, 5'd1, ERR_NONE}},
		'{KIND_PUSH, 32'h0000_0001, 8'h01, 5'd1,  1'b0, NO_RES}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;   // asserted from time zero

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_stack_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	// sorted-stack model: slot 0 is the head, highest priority first
	logic [31:0] stk_elem [DEPTH];
	logic [7:0]  stk_prio [DEPTH];
	int          stk_cnt = 0;

	head_t head_q [$];   // expected results, oldest first
	tag_t  tag_q [$];    // sender notes, one per offered item, in order
	int    fail_cnt = 0;
	int    idle_cycles = 0;
	bit    long_hold = 1'b0;   // main asks the receiver for one long stall

	// idle-gap state per side: runs of gap-free items alternate with random gaps
	int snd_left = 0;
	bit snd_quiet = 1'b0;

	// Apply one operation to the model and return the head/status after it.
	function automatic head_t stack_apply(input logic k, input logic [31:0] e,
			input logic [7:0] p);
		head_t r;
		int    pos;
		int    i;
		r.err = ERR_NONE;
		if (k == KIND_PUSH) begin
			if (stk_cnt >= DEPTH) begin
				r.err = ERR_FULL;
			end else begin
				// insert ahead of the first entry with prio <= p (LIFO on ties)
				pos = 0;
				while (pos < stk_cnt && stk_prio[pos] > p)
					pos++;
				for (i = stk_cnt; i > pos; i--) begin
					stk_elem[i] = stk_elem[i-1];
					stk_prio[i] = stk_prio[i-1];
				end
				stk_elem[pos] = e;
				stk_prio[pos] = p;
				stk_cnt++;
			end
		end else begin
			if (stk_cnt == 0) begin
				r.err = ERR_EMPTY;
			end else begin
				for (i = 0; i + 1 < stk_cnt; i++) begin
					stk_elem[i] = stk_elem[i+1];
					stk_prio[i] = stk_prio[i+1];
				end
				stk_cnt--;
			end
		end
		if (stk_cnt == 0) begin
			r.elem  = '0;
			r.prio  = '0;
			r.empty = 1'b1;
		end else begin
			r.elem  = stk_elem[0];
			r.prio  = stk_prio[0];
			r.empty = 1'b0;
		end
		r.cnt = stk_cnt[4:0];
		return r;
	endfunction

	function automatic int next_gap(ref int left, ref bit quiet);
		if (left == 0) begin
			quiet = ($urandom_range(0, 3) == 0);
			left  = $urandom_range(10, 60);
		end
		left--;
		return quiet ? 0 : int'($urandom_range(0, 16));
	endfunction

	function automatic void flag_fail(input string what, input head_t want, input head_t got);
		fail_cnt++;
		if (fail_cnt <= MAX_REPORTS)
			$display("%s: expected elem=%h prio=%h empty=%0b count=%0d error=%0d,",
				what, want.elem, want.prio, want.empty, want.cnt, want.err,
				" got elem=%h prio=%h empty=%0b count=%0d error=%0d",
				got.elem, got.prio, got.empty, got.cnt, got.err);
	endfunction

	// Offer one item after a random gap; returns at the edge it is accepted.
	// valid stays high into the next item when its gap is zero.
	task automatic offer(input logic k, input logic [31:0] e, input logic [7:0] p,
			input tag_t tag);
		int gap;
		gap = next_gap(snd_left, snd_quiet);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tag_q.push_back(tag);
		req_ch.valid <= 1'b1;
		req_ch.kind  <= k;
		req_ch.elem  <= e;
		req_ch.prio  <= p;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Receiver: random ready gaps, plus one long hold-off on request. The hold
	// is folded into the gap so ready never gets two updates in one step.
	initial begin
		int rcv_left;
		bit rcv_quiet;
		int wait_cycles;
		rcv_left  = 0;
		rcv_quiet = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			wait_cycles = next_gap(rcv_left, rcv_quiet);
			if (long_hold) begin
				wait_cycles += HOLD_CYCLES;
				long_hold = 1'b0;
			end
			if (wait_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Monitors: predict on each accepted request, check each accepted result.
	// All reads here see pre-edge values since every driver uses NBAs.
	tag_t  acc_tag;
	head_t want;
	head_t got;
	head_t pred;
	bit    moved;

	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (req_ch.valid && req_ch.ready) begin
				moved   = 1'b1;
				acc_tag = tag_q.pop_front();
				// model always steps, even when the row carries its own answer
				pred    = stack_apply(req_ch.kind, req_ch.elem, req_ch.prio);
				head_q.push_back(acc_tag.given ? acc_tag.res : pred);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				moved = 1'b1;
				got   = '{rsp_ch.top_elem, rsp_ch.top_prio, rsp_ch.empty_flag, rsp_ch.count,
					spq_err_t'(rsp_ch.error)};
				if (head_q.size() == 0) begin
					flag_fail("result with nothing expected", NO_RES, got);
				end else begin
					want = head_q.pop_front();
					if (got.elem !== want.elem || got.prio !== want.prio ||
							got.empty !== want.empty || got.cnt !== want.cnt ||
							got.err !== want.err)
						flag_fail("mismatch", want, got);
				end
			end
			// watchdog: a long run with no handshake anywhere means a hang
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int          n;
		int          r;
		int          phase;
		int          pmode;
		int          phase_left;
		int          push_pct;
		logic        k;
		logic [7:0]  p;
		logic [31:0] e;
		req_ch.valid <= 1'b0;
		req_ch.kind  <= KIND_PUSH;
		req_ch.elem  <= '0;
		req_ch.prio  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (n = 0; n < N_ROWS; n++) begin
			for (r = 0; r < PLAN[n].reps; r++) begin
				e = (PLAN[n].kind == KIND_PUSH) ? PLAN[n].elem + r : PLAN[n].elem;
				offer(PLAN[n].kind, e, PLAN[n].prio, '{PLAN[n].given, PLAN[n].res});
			end
		end

		// random traffic in phases: push-heavy runs reach full, pop-heavy runs
		// reach empty, balanced runs churn in the middle; the priority mode
		// varies between wide spread, dense ties and the extremes
		phase      = 0;
		pmode      = 0;
		phase_left = 0;
		for (n = 0; n < N_RANDOM; n++) begin
			if (phase_left == 0) begin
				phase      = $urandom_range(0, 2);
				pmode      = $urandom_range(0, 3);
				phase_left = $urandom_range(20, 70);
			end
			phase_left--;
			case (phase)
				0: push_pct = 80;
				1: push_pct = 25;
				default: push_pct = 50;
			endcase
			k = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
			case (pmode)
				0: p = 8'($urandom_range(0, 255));
				1: p = 8'($urandom_range(0, 3));
				2: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				default: p = $urandom_range(0, 1) ? 8'($urandom_range(250, 255))
					: 8'($urandom_range(0, 5));
			endcase
			// one long result stall while the sender keeps offering
			if (n == N_RANDOM / 3)
				long_hold = 1'b1;
			offer(k, $urandom(), p, '{1'b0, NO_RES});
		end
		req_ch.valid <= 1'b0;

		// drain, then a few more cycles for any stray result
		while (head_q.size() != 0 || tag_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && head_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
